// ===== src/top_down_free_list_allocator_macros.svh =====
// assertion helpers used by the allocator datapath
`ifndef TOP_DOWN_FREE_LIST_ALLOCATOR_MACROS_SVH
`define TOP_DOWN_FREE_LIST_ALLOCATOR_MACROS_SVH

// checked only while out of reset
`define TDFLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TDFLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/tdfla_pkg.sv =====
`default_nettype none
package tdfla_pkg;

    localparam int MAX_FREE_BLOCKS_DEF = 16;
    localparam int MAX_SLOTS_DEF       = 16;

    localparam int ADDR_W  = 22;
    localparam int REQ_W   = 2;
    localparam int ID_W    = 4;
    localparam int CFG_W   = 1;
    localparam int NEED_W  = ADDR_W + 2;

    localparam logic [ADDR_W-1:0] REGION_RESET = ADDR_W'(1048576);

    localparam logic [CFG_W-1:0] CFG_REGION  = 1'b0;
    localparam logic [CFG_W-1:0] CFG_RESERVE = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_ALLOC_INIT,
        OP_REALLOC_INIT,
        OP_ALLOC_STEP,
        OP_SHIFT_STEP,
        OP_FREE_INIT,
        OP_FREE_STEP,
        OP_OVF,
        OP_COPY_INIT,
        OP_COPY_STEP,
        OP_LOW_INIT,
        OP_LOW_STEP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic in_range;
        logic hit;
        logic k_zero;
        logic fit;
        logic exact;
        logic shift_last;
        logic free_last;
        logic mc_over;
        logic copy_last;
        logic low_last;
    } t_status;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] low;
        logic              need;
        logic              ovf;
    } t_res;

endpackage
`default_nettype wire

// ===== src/tdfla_ctrl.sv =====
`default_nettype none
module tdfla_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_out_free,
    input  tdfla_pkg::t_status   i_st,
    output tdfla_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ALLOC, S_SHIFT, S_FREE, S_FCHK,
        S_COPY, S_RINIT, S_LOWI, S_LOW, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = tdfla_pkg::OP_NONE;
        o_cmd.load = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = tdfla_pkg::OP_START;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.req == tdfla_pkg::REQ_QUERY || !i_st.in_range) begin
                    n_state = S_LOWI;
                end else if (i_st.req == tdfla_pkg::REQ_ALLOC) begin
                    if (i_st.hit) begin
                        n_state = S_LOWI;
                    end else begin
                        o_cmd.op = tdfla_pkg::OP_ALLOC_INIT;
                        n_state  = S_ALLOC;
                    end
                end else if (!i_st.hit) begin
                    n_state = S_LOWI;
                end else begin
                    o_cmd.op = tdfla_pkg::OP_FREE_INIT;
                    n_state  = S_FREE;
                end
            end
            S_ALLOC: begin
                o_cmd.op = tdfla_pkg::OP_ALLOC_STEP;
                if (i_st.k_zero) begin
                    n_state = S_LOWI;
                end else if (i_st.fit) begin
                    n_state = i_st.exact ? S_SHIFT : S_LOWI;
                end
            end
            S_SHIFT: begin
                o_cmd.op = tdfla_pkg::OP_SHIFT_STEP;
                if (i_st.shift_last) begin
                    n_state = S_LOWI;
                end
            end
            S_FREE: begin
                o_cmd.op = tdfla_pkg::OP_FREE_STEP;
                if (i_st.free_last) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_st.mc_over) begin
                    o_cmd.op = tdfla_pkg::OP_OVF;
                    n_state  = S_LOWI;
                end else begin
                    o_cmd.op = tdfla_pkg::OP_COPY_INIT;
                    n_state  = S_COPY;
                end
            end
            S_COPY: begin
                o_cmd.op = tdfla_pkg::OP_COPY_STEP;
                if (i_st.copy_last) begin
                    n_state = (i_st.req == tdfla_pkg::REQ_REALLOC) ? S_RINIT : S_LOWI;
                end
            end
            S_RINIT: begin
                o_cmd.op = tdfla_pkg::OP_REALLOC_INIT;
                n_state  = S_ALLOC;
            end
            S_LOWI: begin
                o_cmd.op = tdfla_pkg::OP_LOW_INIT;
                n_state  = S_LOW;
            end
            S_LOW: begin
                o_cmd.op = tdfla_pkg::OP_LOW_STEP;
                if (i_st.low_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== src/tdfla_dp.sv =====
`default_nettype none
`include "top_down_free_list_allocator_macros.svh"
module tdfla_dp #(
    parameter int MAX_FREE_BLOCKS = tdfla_pkg::MAX_FREE_BLOCKS_DEF,
    parameter int MAX_SLOTS       = tdfla_pkg::MAX_SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tdfla_pkg::t_cmd                    i_cmd,
    output tdfla_pkg::t_status                 o_st,
    output tdfla_pkg::t_res                    o_res,
    input  wire [tdfla_pkg::REQ_W-1:0]         i_req_type,
    input  wire [tdfla_pkg::ID_W-1:0]          i_tensor_id,
    input  wire [tdfla_pkg::ADDR_W-1:0]        i_req_size,
    input  wire [tdfla_pkg::ADDR_W-1:0]        i_cb_peak,
    input  wire [tdfla_pkg::ADDR_W-1:0]        i_extra_usage,
    input  wire                                i_cfg_we,
    input  wire [tdfla_pkg::CFG_W-1:0]         i_cfg_idx,
    input  wire [tdfla_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int AW     = tdfla_pkg::ADDR_W;
    localparam int IW     = tdfla_pkg::ID_W;
    localparam int FIDX_W = $clog2(MAX_FREE_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int MC_W   = $clog2(MAX_FREE_BLOCKS + 2);
    localparam int SIDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW     = tdfla_pkg::NEED_W;

    logic [AW-1:0]     r_fs [MAX_FREE_BLOCKS];
    logic [AW-1:0]     r_fe [MAX_FREE_BLOCKS];
    logic [AW-1:0]     r_ts [MAX_FREE_BLOCKS];
    logic [AW-1:0]     r_te [MAX_FREE_BLOCKS];
    logic              r_sv [MAX_SLOTS];
    logic [AW-1:0]     r_ss [MAX_SLOTS];
    logic [AW-1:0]     r_sz [MAX_SLOTS];
    logic [CNT_W-1:0]  r_cnt;
    logic [AW-1:0]     r_region;
    logic [AW-1:0]     r_reserve;

    tdfla_pkg::t_req   r_req;
    logic [IW-1:0]     r_id;
    logic [AW-1:0]     r_size;
    logic [AW-1:0]     r_cb;
    logic [AW-1:0]     r_extra;
    logic [AW-1:0]     r_asize;
    logic [AW-1:0]     r_fsz;
    logic [AW-1:0]     r_ns;
    logic [AW-1:0]     r_ne;
    logic [CNT_W-1:0]  r_k;
    logic [FIDX_W-1:0] r_j;
    logic [CNT_W-1:0]  r_i;
    logic [MC_W-1:0]   r_mc;
    logic              r_placed;
    logic              r_have;
    logic [AW-1:0]     r_cs;
    logic [AW-1:0]     r_ce;
    logic [SIDX_W-1:0] r_lidx;
    logic [AW-1:0]     r_low;
    logic              r_ok;
    logic              r_ovf;
    logic [AW-1:0]     r_addr;

    logic [SIDX_W+IW-1:0] id_ext;
    logic [SIDX_W-1:0]    slot_idx;
    logic                 sv_rd;
    logic [AW-1:0]        ss_rd;
    logic [AW-1:0]        sz_rd;
    logic [CNT_W-1:0]     f_pos;
    logic [FIDX_W-1:0]    f_idx;
    logic [AW-1:0]        fs_rd;
    logic [AW-1:0]        fe_rd;
    logic [AW-1:0]        span;
    logic [AW-1:0]        take_addr;
    logic [CNT_W-1:0]     j_next;
    logic                 at_end;
    logic                 take_new;
    logic                 emit;
    logic [AW-1:0]        elem_s;
    logic [AW-1:0]        elem_e;
    logic [AW-1:0]        end_sum;
    logic [AW-1:0]        end_calc;
    logic [NW-1:0]        need_sum;
    logic                 fit_now;
    logic                 copy_now;

    assign id_ext   = {{SIDX_W{1'b0}}, r_id};
    assign slot_idx = (i_cmd.op == tdfla_pkg::OP_LOW_STEP) ? r_lidx : id_ext[SIDX_W-1:0];
    assign sv_rd    = r_sv[slot_idx];
    assign ss_rd    = r_ss[slot_idx];
    assign sz_rd    = r_sz[slot_idx];

    assign j_next = CNT_W'(r_j) + CNT_W'(1);

    always_comb begin
        case (i_cmd.op)
            tdfla_pkg::OP_ALLOC_STEP: f_pos = r_k - CNT_W'(1);
            tdfla_pkg::OP_SHIFT_STEP: f_pos = j_next;
            default:                  f_pos = r_i;
        endcase
    end

    assign f_idx     = (32'(f_pos) < MAX_FREE_BLOCKS) ? f_pos[FIDX_W-1:0] : '0;
    assign fs_rd     = r_fs[f_idx];
    assign fe_rd     = r_fe[f_idx];
    assign span      = (fe_rd >= fs_rd) ? (fe_rd - fs_rd) : '0;
    assign take_addr = fe_rd - r_asize;

    // merge stream: the freed range slots in before the first block above it
    assign at_end   = (r_i == r_cnt);
    assign take_new = !r_placed && (at_end || (fs_rd > r_ns));
    assign elem_s   = take_new ? r_ns : fs_rd;
    assign elem_e   = take_new ? r_ne : fe_rd;
    assign emit     = (r_placed && at_end) || (r_have && (r_ce < elem_s));

    assign end_sum  = ss_rd + sz_rd;
    assign end_calc = (end_sum < ss_rd) ? ss_rd : end_sum;

    assign need_sum = NW'(r_cb) + NW'(r_extra) + NW'(r_reserve);

    assign fit_now  = (i_cmd.op == tdfla_pkg::OP_ALLOC_STEP) && (r_k != '0) && (span >= r_asize);
    assign copy_now = (i_cmd.op == tdfla_pkg::OP_COPY_STEP);

    always_comb begin
        o_st.req        = r_req;
        o_st.in_range   = (32'(r_id) < MAX_SLOTS);
        o_st.hit        = sv_rd;
        o_st.k_zero     = (r_k == '0);
        o_st.fit        = (span >= r_asize);
        o_st.exact      = (span == r_asize);
        o_st.shift_last = (j_next >= r_cnt);
        o_st.free_last  = r_placed && at_end;
        o_st.mc_over    = (32'(r_mc) > MAX_FREE_BLOCKS);
        o_st.copy_last  = ((MC_W'(r_j) + MC_W'(1)) == r_mc);
        o_st.low_last   = (32'(r_lidx) == MAX_SLOTS - 1);

        o_res.ok   = r_ok;
        o_res.addr = r_addr;
        o_res.low  = r_low;
        o_res.need = (r_req == tdfla_pkg::REQ_QUERY) && (need_sum >= NW'(r_low));
        o_res.ovf  = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs[0]   <= '0;
            r_fe[0]   <= tdfla_pkg::REGION_RESET;
            r_cnt     <= CNT_W'(1);
            r_region  <= tdfla_pkg::REGION_RESET;
            r_reserve <= '0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                r_sv[s] <= 1'b0;
            end
            r_ok  <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            case (i_cmd.op)
                tdfla_pkg::OP_START: begin
                    r_req   <= tdfla_pkg::t_req'(i_req_type);
                    r_id    <= i_tensor_id;
                    r_size  <= i_req_size;
                    r_cb    <= i_cb_peak;
                    r_extra <= i_extra_usage;
                    r_ok    <= (tdfla_pkg::t_req'(i_req_type) == tdfla_pkg::REQ_QUERY);
                    r_ovf   <= 1'b0;
                    r_addr  <= '0;
                end
                tdfla_pkg::OP_ALLOC_INIT: begin
                    r_k     <= r_cnt;
                    r_asize <= r_size;
                end
                tdfla_pkg::OP_REALLOC_INIT: begin
                    r_k     <= r_cnt;
                    r_asize <= r_fsz;
                end
                tdfla_pkg::OP_ALLOC_STEP: begin
                    if (r_k == '0) begin
                        r_ok   <= 1'b0;
                        r_addr <= '0;
                    end else if (span >= r_asize) begin
                        r_ok           <= 1'b1;
                        r_addr         <= take_addr;
                        r_sv[slot_idx] <= 1'b1;
                        r_ss[slot_idx] <= take_addr;
                        r_sz[slot_idx] <= r_asize;
                        if (span == r_asize) begin
                            r_j <= f_idx;
                        end else begin
                            r_fe[f_idx] <= take_addr;
                        end
                    end else begin
                        r_k <= r_k - CNT_W'(1);
                    end
                end
                tdfla_pkg::OP_SHIFT_STEP: begin
                    if (j_next < r_cnt) begin
                        r_fs[r_j] <= fs_rd;
                        r_fe[r_j] <= fe_rd;
                        r_j       <= r_j + FIDX_W'(1);
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                tdfla_pkg::OP_FREE_INIT: begin
                    r_ns     <= ss_rd;
                    r_ne     <= end_calc;
                    r_fsz    <= sz_rd;
                    r_i      <= '0;
                    r_mc     <= '0;
                    r_placed <= 1'b0;
                    r_have   <= 1'b0;
                end
                tdfla_pkg::OP_FREE_STEP: begin
                    if (emit) begin
                        if (32'(r_mc) < MAX_FREE_BLOCKS) begin
                            r_ts[r_mc[FIDX_W-1:0]] <= r_cs;
                            r_te[r_mc[FIDX_W-1:0]] <= r_ce;
                        end
                        r_mc <= r_mc + MC_W'(1);
                    end
                    if (!(r_placed && at_end)) begin
                        if (take_new) begin
                            r_placed <= 1'b1;
                        end else begin
                            r_i <= r_i + CNT_W'(1);
                        end
                        if (!r_have || emit) begin
                            r_cs   <= elem_s;
                            r_ce   <= elem_e;
                            r_have <= 1'b1;
                        end else if (elem_e > r_ce) begin
                            r_ce <= elem_e;
                        end
                    end
                end
                tdfla_pkg::OP_OVF: begin
                    r_ovf <= 1'b1;
                    r_ok  <= 1'b0;
                end
                tdfla_pkg::OP_COPY_INIT: begin
                    r_j <= '0;
                end
                tdfla_pkg::OP_COPY_STEP: begin
                    r_fs[r_j] <= r_ts[r_j];
                    r_fe[r_j] <= r_te[r_j];
                    r_j       <= r_j + FIDX_W'(1);
                    if ((MC_W'(r_j) + MC_W'(1)) == r_mc) begin
                        r_cnt          <= CNT_W'(r_mc);
                        r_sv[slot_idx] <= 1'b0;
                        r_ok           <= 1'b1;
                    end
                end
                tdfla_pkg::OP_LOW_INIT: begin
                    r_low  <= r_region;
                    r_lidx <= '0;
                end
                tdfla_pkg::OP_LOW_STEP: begin
                    if (sv_rd && (ss_rd < r_low)) begin
                        r_low <= ss_rd;
                    end
                    r_lidx <= r_lidx + SIDX_W'(1);
                end
                default: ;
            endcase

            if (i_cfg_we) begin
                if (i_cfg_idx == tdfla_pkg::CFG_REGION) begin
                    r_region <= i_cfg_data;
                    r_fs[0]  <= '0;
                    r_fe[0]  <= i_cfg_data;
                    r_cnt    <= CNT_W'(1);
                    for (int s = 0; s < MAX_SLOTS; s++) begin
                        r_sv[s] <= 1'b0;
                    end
                end else if (i_cfg_idx == tdfla_pkg::CFG_RESERVE) begin
                    r_reserve <= i_cfg_data;
                end
            end
        end
    end

    // an exact fit of the last block leaves the list empty
    `TDFLA_ASSERT(a_cnt_range, (32'(r_cnt) <= MAX_FREE_BLOCKS), "free count out of range")
    `TDFLA_ASSERT(a_copy_fits, copy_now |-> (32'(r_mc) <= MAX_FREE_BLOCKS), "copy of an overflowed list")
    `TDFLA_ASSERT(a_fit_marks_slot, fit_now |=> (r_ok && r_sv[slot_idx]), "fit did not take the slot")

endmodule
`default_nettype wire

// ===== src/top_down_free_list_allocator.sv =====
// channel   | handshake          | payload
// request   | i_valid / o_ready  | i_req_type i_tensor_id i_req_size i_cb_peak i_extra_usage
// result    | o_valid / i_ready  | o_ok o_address o_lowest_address o_need_realloc o_overflow
// config    | i_cfg_we           | i_cfg_idx i_cfg_data
//
// one word at a time: a new request is taken only after the last one has gone to the result register
// allocate walks free blocks from the top, one per cycle, then shifts on an exact fit
// free streams the list through the merge unit, then copies the merged list back if it fits
// the lowest-address scan visits one slot per cycle, every slot on each request
// reset is synchronous; the result register lets a new word in while the last waits
`default_nettype none
module top_down_free_list_allocator #(
    parameter int MAX_FREE_BLOCKS = tdfla_pkg::MAX_FREE_BLOCKS_DEF,
    parameter int MAX_SLOTS       = tdfla_pkg::MAX_SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [tdfla_pkg::REQ_W-1:0]   i_req_type,
    input  wire [tdfla_pkg::ID_W-1:0]    i_tensor_id,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_req_size,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_cb_peak,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_extra_usage,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_ok,
    output logic [tdfla_pkg::ADDR_W-1:0] o_address,
    output logic [tdfla_pkg::ADDR_W-1:0] o_lowest_address,
    output logic                         o_need_realloc,
    output logic                         o_overflow,
    input  wire                          i_cfg_we,
    input  wire [tdfla_pkg::CFG_W-1:0]   i_cfg_idx,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_cfg_data
);

    tdfla_pkg::t_cmd    cmd;
    tdfla_pkg::t_status st;
    tdfla_pkg::t_res    res;
    tdfla_pkg::t_res    r_out;
    logic               r_valid;
    logic               out_free;

    assign out_free = !r_valid || i_ready;

    tdfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_out_free (out_free),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tdfla_dp #(
        .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
        .MAX_SLOTS       (MAX_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_res         (res),
        .i_req_type    (i_req_type),
        .i_tensor_id   (i_tensor_id),
        .i_req_size    (i_req_size),
        .i_cb_peak     (i_cb_peak),
        .i_extra_usage (i_extra_usage),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_valid;
    assign o_ok             = r_out.ok;
    assign o_address        = r_out.addr;
    assign o_lowest_address = r_out.low;
    assign o_need_realloc   = r_out.need;
    assign o_overflow       = r_out.ovf;

endmodule
`default_nettype wire

// ===== tb/tdfla_checker.sv =====
`default_nettype none
module tdfla_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire                          i_o_ready,
    input  wire [tdfla_pkg::REQ_W-1:0]   i_req_type,
    input  wire [tdfla_pkg::ID_W-1:0]    i_tensor_id,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_req_size,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_cb_peak,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_extra_usage,
    input  wire                          i_o_valid,
    input  wire                          i_ready,
    input  wire                          i_ok,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_address,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_lowest_address,
    input  wire                          i_need_realloc,
    input  wire                          i_overflow,
    input  wire                          i_cfg_we,
    input  wire [tdfla_pkg::CFG_W-1:0]   i_cfg_idx,
    input  wire [tdfla_pkg::ADDR_W-1:0]  i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int NBLK = tdfla_pkg::MAX_FREE_BLOCKS_DEF;
    localparam int NSLOT = tdfla_pkg::MAX_SLOTS_DEF;
    localparam int AW = tdfla_pkg::ADDR_W;

    typedef logic [AW-1:0] t_addr;

    t_addr region_sz;
    t_addr reserve_sz;
    t_addr blk_start [NBLK];
    t_addr blk_end [NBLK];
    int    blk_cnt;
    logic  slot_used [NSLOT];
    t_addr slot_base [NSLOT];
    t_addr slot_len [NSLOT];
    tdfla_pkg::t_res result_q[$];

    initial o_errors = 0;
    initial o_pending = 0;

    function automatic void clear_allocator();
        for (int i = 0; i < NBLK; i++) begin
            blk_start[i] = '0;
            blk_end[i] = '0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            slot_used[i] = 1'b0;
            slot_base[i] = '0;
            slot_len[i] = '0;
        end
        blk_end[0] = region_sz;
        blk_cnt = 1;
    endfunction

    // top-down first fit
    function automatic logic carve(int id, t_addr len, output t_addr addr);
        t_addr span;
        addr = '0;
        for (int b = blk_cnt - 1; b >= 0; b--) begin
            span = (blk_end[b] >= blk_start[b]) ? blk_end[b] - blk_start[b] : '0;
            if (span < len) continue;
            addr = blk_end[b] - len;
            slot_used[id] = 1'b1;
            slot_base[id] = addr;
            slot_len[id] = len;
            if (span == len) begin
                for (int j = b; j + 1 < blk_cnt; j++) begin
                    blk_start[j] = blk_start[j+1];
                    blk_end[j] = blk_end[j+1];
                end
                blk_cnt--;
            end else begin
                blk_end[b] = blk_end[b] - len;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // sorted insert then coalesce touching or overlapping blocks
    function automatic logic release_slot(int id, output logic ovf);
        t_addr ts [NBLK+1];
        t_addr te [NBLK+1];
        t_addr ns;
        t_addr ne;
        int    n;
        int    mc;
        logic  placed;
        ovf = 1'b0;
        ns = slot_base[id];
        ne = slot_base[id] + slot_len[id];
        if (ne < ns) ne = ns;
        n = 0;
        mc = 0;
        placed = 1'b0;
        for (int i = 0; i < blk_cnt; i++) begin
            if (!placed && blk_start[i] > ns) begin
                ts[n] = ns; te[n] = ne; n++;
                placed = 1'b1;
            end
            ts[n] = blk_start[i]; te[n] = blk_end[i]; n++;
        end
        if (!placed) begin
            ts[n] = ns; te[n] = ne; n++;
        end
        for (int i = 0; i < n; i++) begin
            if (mc == 0 || te[mc-1] < ts[i]) begin
                ts[mc] = ts[i]; te[mc] = te[i]; mc++;
            end else if (te[i] > te[mc-1]) begin
                te[mc-1] = te[i];
            end
        end
        if (mc > NBLK) begin
            ovf = 1'b1;
            return 1'b0;
        end
        for (int i = 0; i < mc; i++) begin
            blk_start[i] = ts[i];
            blk_end[i] = te[i];
        end
        blk_cnt = mc;
        slot_used[id] = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_addr lowest_base();
        t_addr low;
        low = region_sz;
        for (int i = 0; i < NSLOT; i++)
            if (slot_used[i] && slot_base[i] < low) low = slot_base[i];
        return low;
    endfunction

    function automatic tdfla_pkg::t_res serve_request(tdfla_pkg::t_req req, int id, t_addr len,
                                                      t_addr cb, t_addr extra);
        tdfla_pkg::t_res r;
        t_addr addr;
        t_addr keep_len;
        logic [AW+1:0] demand;
        r = '0;
        addr = '0;
        if (req == tdfla_pkg::REQ_QUERY) begin
            demand = {2'b00, cb} + {2'b00, extra} + {2'b00, reserve_sz};
            r.need = demand >= {2'b00, lowest_base()};
            r.ok = 1'b1;
        end else if (req == tdfla_pkg::REQ_ALLOC) begin
            if (!slot_used[id]) r.ok = carve(id, len, addr);
        end else if (req == tdfla_pkg::REQ_FREE) begin
            if (slot_used[id]) r.ok = release_slot(id, r.ovf);
        end else begin
            if (slot_used[id]) begin
                keep_len = slot_len[id];
                if (release_slot(id, r.ovf)) r.ok = carve(id, keep_len, addr);
            end
        end
        r.addr = r.ok ? addr : '0;
        r.low = lowest_base();
        return r;
    endfunction

    always @(posedge i_clk) begin
        tdfla_pkg::t_res got;
        tdfla_pkg::t_res want;
        if (!i_rst_n) begin
            region_sz = tdfla_pkg::REGION_RESET;
            reserve_sz = '0;
            clear_allocator();
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tdfla_pkg::CFG_REGION) begin
                    region_sz = i_cfg_data;
                    clear_allocator();
                end else if (i_cfg_idx == tdfla_pkg::CFG_RESERVE) begin
                    reserve_sz = i_cfg_data;
                end
            end
            if (i_o_valid && i_ready) begin
                got = '{ok: i_ok, addr: i_address, low: i_lowest_address,
                        need: i_need_realloc, ovf: i_overflow};
                if (result_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (i_valid && i_o_ready)
                result_q = {result_q, serve_request(tdfla_pkg::t_req'(i_req_type),
                                                    int'(i_tensor_id), i_req_size,
                                                    i_cb_peak, i_extra_usage)};
        end
        o_pending = result_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/top_down_free_list_allocator_tb.sv =====
`default_nettype none
module top_down_free_list_allocator_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int AW = tdfla_pkg::ADDR_W;
    localparam int IDW = tdfla_pkg::ID_W;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic [tdfla_pkg::REQ_W-1:0] i_req_type = '0;
    logic [IDW-1:0]              i_tensor_id = '0;
    logic [AW-1:0]               i_req_size = '0;
    logic [AW-1:0]               i_cb_peak = '0;
    logic [AW-1:0]               i_extra_usage = '0;
    logic                        i_ready = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [tdfla_pkg::CFG_W-1:0] i_cfg_idx = '0;
    logic [AW-1:0]               i_cfg_data = '0;
    wire                         o_ready;
    wire                         o_valid;
    wire                         o_ok;
    wire [AW-1:0]                o_address;
    wire [AW-1:0]                o_lowest_address;
    wire                         o_need_realloc;
    wire                         o_overflow;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;
    logic [AW-1:0] region_now = tdfla_pkg::REGION_RESET;

    top_down_free_list_allocator uut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req_type, .i_tensor_id, .i_req_size,
        .i_cb_peak, .i_extra_usage, .o_valid, .i_ready, .o_ok, .o_address,
        .o_lowest_address, .o_need_realloc, .o_overflow, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    tdfla_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_o_ready(o_ready), .i_req_type, .i_tensor_id,
        .i_req_size, .i_cb_peak, .i_extra_usage, .i_o_valid(o_valid), .i_ready,
        .i_ok(o_ok), .i_address(o_address), .i_lowest_address(o_lowest_address),
        .i_need_realloc(o_need_realloc), .i_overflow(o_overflow), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: long hold-off when asked, random stalls otherwise
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_word(tdfla_pkg::t_req req, logic [IDW-1:0] id, logic [AW-1:0] len,
                             logic [AW-1:0] cb, logic [AW-1:0] extra);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_tensor_id <= id;
        i_req_size <= len;
        i_cb_peak <= cb;
        i_extra_usage <= extra;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [tdfla_pkg::CFG_W-1:0] idx, logic [AW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == tdfla_pkg::CFG_REGION) region_now = data;
    endtask

    function automatic logic [AW-1:0] pick_len();
        case ($urandom_range(9))
            0: return '0;
            1, 2, 3, 4, 5: return AW'($urandom_range(1, 64));
            6, 7: return AW'($urandom_range(1, 4096));
            8: return AW'($urandom_range(0, region_now));
            default: return AW'($urandom);
        endcase
    endfunction

    function automatic logic [AW-1:0] pick_usage();
        return $urandom_range(1) ? AW'($urandom) : AW'($urandom_range(0, 2000));
    endfunction

    task automatic random_word();
        int roll;
        tdfla_pkg::t_req req;
        roll = $urandom_range(99);
        if (roll < 45) req = tdfla_pkg::REQ_ALLOC;
        else if (roll < 70) req = tdfla_pkg::REQ_FREE;
        else if (roll < 85) req = tdfla_pkg::REQ_REALLOC;
        else req = tdfla_pkg::REQ_QUERY;
        send_word(req, IDW'($urandom), pick_len(), pick_usage(), pick_usage());
    endtask

    initial begin
        logic [AW-1:0] regions [5];
        logic [AW-1:0] reserves [5];
        regions = '{tdfla_pkg::REGION_RESET, 22'd2097152, 22'd0, 22'd64, 22'd1000};
        reserves = '{22'd0, 22'd2097152, 22'd12345, 22'd5, 22'h2aaaaa};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed word sequence on the reset configuration
        // exact fit empties the list, then nothing is left to fit
        send_word(tdfla_pkg::REQ_ALLOC, 4'd0, 22'd1048576, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd1, '0, '0, '0);
        send_word(tdfla_pkg::REQ_QUERY, 4'd0, '0, 22'h3fffff, 22'h3fffff);
        send_word(tdfla_pkg::REQ_QUERY, 4'd15, 22'h3fffff, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd0, 22'd5, '0, '0);         // slot already taken
        send_word(tdfla_pkg::REQ_FREE, 4'd1, '0, '0, '0);             // empty slot
        send_word(tdfla_pkg::REQ_REALLOC, 4'd0, '0, '0, '0);
        send_word(tdfla_pkg::REQ_FREE, 4'd0, '0, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd2, 22'h3fffff, '0, '0);    // too large
        send_word(tdfla_pkg::REQ_ALLOC, 4'd2, '0, '0, '0);            // zero size at the top
        send_word(tdfla_pkg::REQ_ALLOC, 4'd3, 22'd16, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd4, 22'd100, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd5, 22'd7, '0, '0);
        send_word(tdfla_pkg::REQ_FREE, 4'd4, '0, '0, '0);             // hole in the middle
        send_word(tdfla_pkg::REQ_REALLOC, 4'd5, '0, '0, '0);
        send_word(tdfla_pkg::REQ_REALLOC, 4'd6, '0, '0, '0);          // empty slot
        send_word(tdfla_pkg::REQ_FREE, 4'd2, '0, '0, '0);
        send_word(tdfla_pkg::REQ_QUERY, 4'd0, '0, 22'd1000, 22'd2000);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd15, 22'h155555, '0, '0);
        send_word(tdfla_pkg::REQ_ALLOC, 4'd14, 22'h0aaaab, '0, '0);
        send_word(tdfla_pkg::REQ_QUERY, 4'd0, '0, 22'h155555, 22'h2aaaaa);
        for (int i = 0; i < 16; i++) send_word(tdfla_pkg::REQ_FREE, IDW'(i), '0, '0, '0);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(tdfla_pkg::CFG_REGION, regions[ph]);
            write_reg(tdfla_pkg::CFG_RESERVE, reserves[ph]);
            i_cfg_we <= 1'b0;
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 53; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 53; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (ph == 1) hold_cycles = 400;
            for (int n = 0; n < 260; n++) begin
                random_word();
                if (n == 130) drain();
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== top_down_free_list_allocator.f =====
+incdir+src
src/tdfla_pkg.sv
src/tdfla_ctrl.sv
src/tdfla_dp.sv
src/top_down_free_list_allocator.sv
tb/tdfla_checker.sv
tb/top_down_free_list_allocator_tb.sv
